FILE: rtl/shfp_pkg.sv
// shared constants and controller/datapath interface types for the frame parser
package shfp_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;

  // default payload length
  localparam int unsigned PAYLOAD_BYTES_DEF = 44;

  // frame marker bytes
  localparam logic [BYTE_W-1:0] HDR_B0       = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_B1       = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_B2       = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_B3       = 8'h08;
  localparam logic [BYTE_W-1:0] PAD_BYTE     = 8'h00;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hAA;

  // controller to datapath commands
  typedef struct packed {
    logic wr_clr;    // rewind write pointer
    logic wr_en;     // store rx byte, advance write pointer
    logic rd_first;  // read entry 0
    logic rd_next;   // read the entry after the current one
    logic out_load;  // load output register from read data
  } shfp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic is_hdr2;
    logic is_hdr3;
    logic is_pad;
    logic is_trl;
    logic wr_last;   // write pointer at final payload entry
    logic rd_last;   // read pointer at final payload entry
  } shfp_sts_t;

endpackage

FILE: rtl/sync_header_frame_parser_top.sv
// top level of the fixed-length sync header frame parser
//
// Bytes enter on the rx channel, one item per cycle, while the parser hunts for the
// header 55 00 02 08, stores PAYLOAD_BYTES payload bytes in an internal ram, and
// checks the pad byte (00) and trailer (aa). A mismatch on any header byte after
// the first, a bad pad or a bad trailer drops back to the hunt; the mismatching
// byte is consumed and not retested as a header start. After a good trailer the
// input channel stalls while the stored payload is sent out as PAYLOAD_BYTES items,
// each with its byte index, last_byte_o set on the final one. The first ram read
// is issued in the cycle the trailer is taken, so from the next cycle on one item
// is loaded per cycle while the output is not stalled; the single read port of the
// payload ram sets that pace. Each item passes the ram read register and then the
// output register before it is valid. The input reopens as soon as the final item
// sits in the output register, so a new frame may start while that item still
// waits to be taken. The ram is not cleared after reset: no entry is read before
// the current frame has written it.
module sync_header_frame_parser_top import shfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // rx byte channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  // payload item channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic              last_byte_o
);

  shfp_cmd_t cmd;
  shfp_sts_t sts;

  // phase sequencing and output valid
  shfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // compares, payload ram, pointers and output payload register
  shfp_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_byte_o    (last_byte_o)
  );

  // a loaded item shows up as valid on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded item not presented");

  // a good trailer closes the input until the burst is loaded
  a_burst_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_first |=> in_stall_o)
    else $error("input open during burst");

  // last flag only on the final payload index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (byte_index_o == IDX_W'(PAYLOAD_BYTES - 1)))
    else $error("last flag on wrong index");

  // the store is never written while the burst reads it
  a_no_wr_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && (cmd.rd_first || cmd.rd_next)))
    else $error("payload write during burst");

endmodule

FILE: rtl/shfp_ram.sv
// generic single-write, single-read ram with registered read data
module shfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 44,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/shfp_ctrl.sv
// frame parser controller: header hunt, payload count, pad/trailer check, burst sequencing
module shfp_ctrl import shfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  shfp_sts_t sts_i,
  output shfp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_HUNT0   = 3'd0,
    S_HUNT1   = 3'd1,
    S_HUNT2   = 3'd2,
    S_HUNT3   = 3'd3,
    S_PAYLOAD = 3'd4,
    S_PAD     = 3'd5,
    S_TRAILER = 3'd6,
    S_EMIT    = 3'd7
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      in_acc;
  logic      out_free;
  shfp_cmd_t cmd;

  assign in_stall_o = (state_q == S_EMIT);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd         = '0;
    unique case (state_q)
      S_HUNT0: begin
        if (in_acc && sts_i.is_hdr0) begin
          state_d = S_HUNT1;
        end
      end
      S_HUNT1: begin
        if (in_acc) begin
          state_d = sts_i.is_hdr1 ? S_HUNT2 : S_HUNT0;
        end
      end
      S_HUNT2: begin
        if (in_acc) begin
          state_d = sts_i.is_hdr2 ? S_HUNT3 : S_HUNT0;
        end
      end
      S_HUNT3: begin
        if (in_acc) begin
          if (sts_i.is_hdr3) begin
            cmd.wr_clr = 1'b1;
            state_d    = S_PAYLOAD;
          end else begin
            state_d = S_HUNT0;
          end
        end
      end
      S_PAYLOAD: begin
        if (in_acc) begin
          cmd.wr_en = 1'b1;
          if (sts_i.wr_last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (in_acc) begin
          state_d = sts_i.is_pad ? S_TRAILER : S_HUNT0;
        end
      end
      S_TRAILER: begin
        if (in_acc) begin
          if (sts_i.is_trl) begin
            cmd.rd_first = 1'b1;
            state_d      = S_EMIT;
          end else begin
            state_d = S_HUNT0;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          if (sts_i.rd_last) begin
            state_d = S_HUNT0;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HUNT0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: rtl/shfp_dp.sv
// frame parser datapath: byte compares, payload store, pointers, output register
module shfp_dp import shfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  shfp_cmd_t         cmd_i,
  output shfp_sts_t         sts_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic              last_byte_o
);

  localparam int unsigned AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_BYTES - 1);

  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]     raddr;
  logic              re;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;
  logic              wr_last, rd_last;

  assign wr_last = (wr_ptr_q == LAST_ADDR);
  assign rd_last = (rd_ptr_q == LAST_ADDR);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (cmd_i.wr_clr) begin
      wr_ptr_d = '0;
    end else if (cmd_i.wr_en) begin
      wr_ptr_d = wr_last ? '0 : AW'(wr_ptr_q + 1'b1);
    end
  end

  assign raddr = cmd_i.rd_first ? '0 : AW'(rd_ptr_q + 1'b1);
  assign re    = cmd_i.rd_first | cmd_i.rd_next;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (re) begin
      rd_ptr_d = raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  shfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_ptr_q),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // index and last flag come from the pointer of the read being loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= rdata;
      out_idx_q  <= IDX_W'(rd_ptr_q);
      out_last_q <= rd_last;
    end
  end

  always_comb begin
    sts_o         = '0;
    sts_o.is_hdr0 = (rx_byte_i == HDR_B0);
    sts_o.is_hdr1 = (rx_byte_i == HDR_B1);
    sts_o.is_hdr2 = (rx_byte_i == HDR_B2);
    sts_o.is_hdr3 = (rx_byte_i == HDR_B3);
    sts_o.is_pad  = (rx_byte_i == PAD_BYTE);
    sts_o.is_trl  = (rx_byte_i == TRAILER_BYTE);
    sts_o.wr_last = wr_last;
    sts_o.rd_last = rd_last;
  end

  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign last_byte_o    = out_last_q;

endmodule
